### rtl/jsm_pkg.sv
// ----------------------------------------------------------------------------
// jsm_pkg
// Shared types, constants and codes for the Julia set membership test.
// ----------------------------------------------------------------------------
package jsm_pkg;

	// Fixed-point format of coordinates, center, c and z
	localparam int FRACTION_BITS = 28;
	localparam int DATA_W        = 32;
	localparam int SCALE_W       = 31;
	localparam int OPND_W        = DATA_W + 1;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int CNT_W         = 8;

	// Configuration port geometry
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	// Rounding offsets and the escape bound 4.0
	localparam logic signed [PROD_W-1:0] RND_HALF   = PROD_W'(1) << (FRACTION_BITS - 1);
	localparam logic signed [PROD_W-1:0] RND_HALF_X2 = PROD_W'(1) << (FRACTION_BITS - 2);
	localparam logic signed [PROD_W-1:0] ESC_BOUND  = PROD_W'(4) << FRACTION_BITS;

	// Register reset values
	localparam logic signed [DATA_W-1:0] RST_CENTER_REAL = '0;
	localparam logic signed [DATA_W-1:0] RST_CENTER_IMAG = '0;
	localparam logic [SCALE_W-1:0]       RST_COORD_SCALE = SCALE_W'(80530637);
	localparam logic signed [DATA_W-1:0] RST_CONST_REAL  = -DATA_W'(134217728);
	localparam logic signed [DATA_W-1:0] RST_CONST_IMAG  = DATA_W'(134217728);
	localparam logic [CNT_W-1:0]         RST_ITER_LIMIT  = CNT_W'(128);

	// Register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_REAL = 3'd0,
		REG_CENTER_IMAG = 3'd1,
		REG_COORD_SCALE = 3'd2,
		REG_CONST_REAL  = 3'd3,
		REG_CONST_IMAG  = 3'd4,
		REG_ITER_LIMIT  = 3'd5
	} reg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic signed [DATA_W-1:0] center_real;
		logic signed [DATA_W-1:0] center_imag;
		logic [SCALE_W-1:0]       coord_scale;
		logic signed [DATA_W-1:0] const_real;
		logic signed [DATA_W-1:0] const_imag;
		logic [CNT_W-1:0]         iteration_limit;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture point minus center
		logic mul_scale;  // multiply offsets by the scale
		logic set_z;      // take rounded z0
		logic mul_iter;   // form zr*zr, zi*zi, zr*zi
		logic step;       // take the new z, advance the count
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic start_oor;  // z0 out of range
		logic escape;     // |z|^2 above 4.0 after a step
		logic last;       // iteration count at the limit
		logic next_oor;   // new z out of range
	} dp_sts_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_MUL,
		ST_SCALE_RND,
		ST_ITER_MUL,
		ST_ITER_UPD,
		ST_HOLD
	} state_t;

endpackage

### rtl/jsm_ifs.sv
// ----------------------------------------------------------------------------
// jsm_point_if / jsm_result_if
// Valid/ready channels for points and results.
// ----------------------------------------------------------------------------
interface jsm_point_if;
	import jsm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface jsm_result_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

### rtl/jsm_cfg.sv
// ----------------------------------------------------------------------------
// jsm_cfg
// APB register file holding center, scale, Julia constant and step limit.
// ----------------------------------------------------------------------------
module jsm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jsm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [jsm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [jsm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output jsm_pkg::cfg_t                   cfg
);
	import jsm_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_real     <= RST_CENTER_REAL;
			cfg_q.center_imag     <= RST_CENTER_IMAG;
			cfg_q.coord_scale     <= RST_COORD_SCALE;
			cfg_q.const_real      <= RST_CONST_REAL;
			cfg_q.const_imag      <= RST_CONST_IMAG;
			cfg_q.iteration_limit <= RST_ITER_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_REAL: cfg_q.center_real     <= pwdata;
				REG_CENTER_IMAG: cfg_q.center_imag     <= pwdata;
				REG_COORD_SCALE: cfg_q.coord_scale     <= pwdata[SCALE_W-1:0];
				REG_CONST_REAL:  cfg_q.const_real      <= pwdata;
				REG_CONST_IMAG:  cfg_q.const_imag      <= pwdata;
				REG_ITER_LIMIT:  cfg_q.iteration_limit <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_CENTER_REAL: prdata = cfg_q.center_real;
			REG_CENTER_IMAG: prdata = cfg_q.center_imag;
			REG_COORD_SCALE: prdata = APB_DATA_W'(cfg_q.coord_scale);
			REG_CONST_REAL:  prdata = cfg_q.const_real;
			REG_CONST_IMAG:  prdata = cfg_q.const_imag;
			REG_ITER_LIMIT:  prdata = APB_DATA_W'(cfg_q.iteration_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/jsm_dp.sv
// ----------------------------------------------------------------------------
// jsm_dp
// Datapath: z registers, three multipliers, rounding, range and escape tests.
// ----------------------------------------------------------------------------
module jsm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jsm_pkg::cfg_t                   cfg,
	input  logic signed [jsm_pkg::DATA_W-1:0] point_x,
	input  logic signed [jsm_pkg::DATA_W-1:0] point_y,
	input  jsm_pkg::dp_cmd_t                cmd,
	output jsm_pkg::dp_sts_t                sts
);
	import jsm_pkg::*;

	// z (or point offset during scaling), 33 bits to hold the offset
	logic signed [OPND_W-1:0] zr_q;
	logic signed [OPND_W-1:0] zi_q;
	logic [CNT_W-1:0]         cnt_q;

	// Registered products
	logic signed [PROD_W-1:0] p_rr_s1;
	logic signed [PROD_W-1:0] p_ii_s1;
	logic signed [PROD_W-1:0] p_ri_s1;

	logic signed [OPND_W-1:0]   scale_op;
	logic signed [OPND_W-1:0]   mb0;
	logic signed [OPND_W-1:0]   mb1;
	logic signed [2*OPND_W-1:0] prod0;
	logic signed [2*OPND_W-1:0] prod1;
	logic signed [2*OPND_W-1:0] prod2;

	logic signed [PROD_W-1:0] t_rr;
	logic signed [PROD_W-1:0] t_ii;
	logic signed [PROD_W-1:0] t_ri;
	logic signed [PROD_W-1:0] s_rr;
	logic signed [PROD_W-1:0] s_ii;
	logic signed [PROD_W-1:0] s_ri;
	logic signed [PROD_W-1:0] nr;
	logic signed [PROD_W-1:0] ni;
	logic signed [PROD_W-1:0] mag;

	// True when a 64-bit value fits a signed 32-bit word
	function automatic logic fits_word(input logic signed [PROD_W-1:0] v);
		return (v[PROD_W-1:DATA_W-1] == '0) || (v[PROD_W-1:DATA_W-1] == '1);
	endfunction

	// Operand selection: scale phase multiplies offsets by the scale
	assign scale_op = $signed({2'b00, cfg.coord_scale});
	assign mb0      = cmd.mul_scale ? scale_op : zr_q;
	assign mb1      = cmd.mul_scale ? scale_op : zi_q;
	assign prod0    = zr_q * mb0;
	assign prod1    = zi_q * mb1;
	assign prod2    = zr_q * zi_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_scale || cmd.mul_iter) begin
			p_rr_s1 <= prod0[PROD_W-1:0];
			p_ii_s1 <= prod1[PROD_W-1:0];
			p_ri_s1 <= prod2[PROD_W-1:0];
		end
	end

	// Round half up; the cross term gets one bit less of shift for 2*zr*zi
	always_comb begin
		t_rr = p_rr_s1 + RND_HALF;
		t_ii = p_ii_s1 + RND_HALF;
		t_ri = p_ri_s1 + RND_HALF_X2;
		s_rr = t_rr >>> FRACTION_BITS;
		s_ii = t_ii >>> FRACTION_BITS;
		s_ri = t_ri >>> (FRACTION_BITS - 1);
		nr   = s_rr - s_ii + PROD_W'(cfg.const_real);
		ni   = s_ri + PROD_W'(cfg.const_imag);
		mag  = s_rr + s_ii;
	end

	// The squares of the current z give both the escape test of the
	// previous step and the next step; z0 itself is never tested.
	assign sts.start_oor = !fits_word(s_rr) || !fits_word(s_ii);
	assign sts.next_oor  = !fits_word(nr) || !fits_word(ni);
	assign sts.escape    = (cnt_q != '0) && (mag > ESC_BOUND);
	assign sts.last      = (cnt_q == cfg.iteration_limit);

	// z registers; a new z is sign-extended from its 32-bit word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q <= OPND_W'(point_x) - OPND_W'(cfg.center_real);
			zi_q <= OPND_W'(point_y) - OPND_W'(cfg.center_imag);
		end else if (cmd.set_z) begin
			zr_q <= OPND_W'($signed(s_rr[DATA_W-1:0]));
			zi_q <= OPND_W'($signed(s_ii[DATA_W-1:0]));
		end else if (cmd.step) begin
			zr_q <= OPND_W'($signed(nr[DATA_W-1:0]));
			zi_q <= OPND_W'($signed(ni[DATA_W-1:0]));
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

### rtl/jsm_ctrl.sv
// ----------------------------------------------------------------------------
// jsm_ctrl
// Sequencer for one point and the result output register.
// ----------------------------------------------------------------------------
module jsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_inside,
	output jsm_pkg::dp_cmd_t  cmd,
	input  jsm_pkg::dp_sts_t  sts
);
	import jsm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   res_q;
	logic   pend_q;
	logic   fin;
	logic   fin_val;
	logic   out_free;
	logic   res_load;

	assign out_free   = !res_valid_q || out_ready;
	assign res_load   = fin && out_free;
	assign out_valid  = res_valid_q;
	assign out_inside = res_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		fin      = 1'b0;
		fin_val  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCALE_MUL;
				end
			end
			ST_SCALE_MUL: begin
				cmd.mul_scale = 1'b1;
				state_d       = ST_SCALE_RND;
			end
			ST_SCALE_RND: begin
				if (sts.start_oor) begin
					fin = 1'b1;
				end else begin
					cmd.set_z = 1'b1;
					state_d   = ST_ITER_MUL;
				end
			end
			ST_ITER_MUL: begin
				cmd.mul_iter = 1'b1;
				state_d      = ST_ITER_UPD;
			end
			ST_ITER_UPD: begin
				if (sts.escape) begin
					fin = 1'b1;
				end else if (sts.last) begin
					fin     = 1'b1;
					fin_val = 1'b1;
				end else if (sts.next_oor) begin
					fin = 1'b1;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_ITER_MUL;
				end
			end
			ST_HOLD: begin
				fin     = 1'b1;
				fin_val = pend_q;
			end
			default: state_d = ST_IDLE;
		endcase
		// A finished point goes to the output register or waits for it
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= fin_val;
		end
		if (fin && !out_free) begin
			pend_q <= fin_val;
		end
	end

endmodule

### rtl/julia_set_membership_test.sv
// ----------------------------------------------------------------------------
// julia_set_membership_test
// Escape-time test of one point against a configured Julia set.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  point    in   valid / ready    point_x, point_y (signed Q4.28)
//  result   out  valid / ready    inside_res
//  apb      in   psel / penable   6 registers at byte address 4*i
//
// A point is accepted, then z0 is formed (multiply, then round), then each
// iteration multiplies, then rounds and updates, and a last multiply and
// round give the escape test of the last iterate. The complex-square
// multipliers and the z registers serve one point at a time, so the next
// point is accepted only after this one has finished.
// Reset brings back the register defaults and leaves the block idle.
// A result waits in an output register; a new point is accepted meanwhile,
// and a point that finishes while the register is still full holds there.
module julia_set_membership_test (
	input  logic                            clk,
	input  logic                            arst_n,
	jsm_point_if.sink                       point,
	jsm_result_if.source                    result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jsm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [jsm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [jsm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import jsm_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;
	logic    out_valid;
	logic    out_inside;

	assign point.ready       = in_ready;
	assign result.valid      = out_valid;
	assign result.inside_res = out_inside;

	// Configuration registers
	jsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	jsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (point.valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (result.ready),
		.out_inside (out_inside),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Arithmetic
	jsm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.point_x (point.point_x),
		.point_y (point.point_y),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

### sim/julia_set_membership_test_checker.sv
// ----------------------------------------------------------------------------
// julia_set_membership_test_checker
// Scoreboard for the Julia set membership test. It follows register writes on
// the configuration port, computes the verdict for every accepted point and
// compares it with the result that comes out of the block, in order.
// ----------------------------------------------------------------------------
module julia_set_membership_test_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	jsm_point_if                           point,
	jsm_result_if                          result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [jsm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [jsm_pkg::APB_DATA_W-1:0] pwdata,
	output int                             errors,
	output int                             outstanding,
	output int                             inside_count,
	output int                             outside_count
);
	import jsm_pkg::*;

	localparam longint Q_LOW     = -(longint'(1) << (DATA_W - 1));
	localparam longint Q_HIGH    = (longint'(1) << (DATA_W - 1)) - 1;
	localparam longint ESC_LIMIT = longint'(4) << FRACTION_BITS;

	typedef struct {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic                     inside_res;
	} verdict_t;

	cfg_t     shadow_cfg;
	verdict_t expected_verdicts[$];

	// Round half up to the given number of fraction bits.
	function automatic longint round_frac(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic bit fits_q(longint v);
		return v >= Q_LOW && v <= Q_HIGH;
	endfunction

	// Escape-time verdict of one point under the given register set.
	function automatic logic julia_point_inside(logic signed [DATA_W-1:0] px,
			logic signed [DATA_W-1:0] py, cfg_t c);
		longint scale;
		longint zr;
		longint zi;
		longint nr;
		longint ni;
		longint sr;
		longint si;
		int     n;
		scale = longint'({33'd0, c.coord_scale});
		zr = round_frac((longint'(px) - longint'($signed(c.center_real))) * scale,
			FRACTION_BITS);
		zi = round_frac((longint'(py) - longint'($signed(c.center_imag))) * scale,
			FRACTION_BITS);
		if (!fits_q(zr) || !fits_q(zi))
			return 1'b0;
		for (n = 0; n < int'(c.iteration_limit); n++) begin
			sr = round_frac(zr * zr, FRACTION_BITS);
			si = round_frac(zi * zi, FRACTION_BITS);
			nr = sr - si + longint'($signed(c.const_real));
			ni = round_frac(zr * zi, FRACTION_BITS - 1) + longint'($signed(c.const_imag));
			if (!fits_q(nr) || !fits_q(ni))
				return 1'b0;
			zr = nr;
			zi = ni;
			if (round_frac(zr * zr, FRACTION_BITS) + round_frac(zi * zi, FRACTION_BITS)
					> ESC_LIMIT)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Count a failure and print one line for it.
	task automatic report_mismatch(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Track requests on both channels and register writes.
	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t v;
		if (!arst_n) begin
			shadow_cfg.center_real     = RST_CENTER_REAL;
			shadow_cfg.center_imag     = RST_CENTER_IMAG;
			shadow_cfg.coord_scale     = RST_COORD_SCALE;
			shadow_cfg.const_real      = RST_CONST_REAL;
			shadow_cfg.const_imag      = RST_CONST_IMAG;
			shadow_cfg.iteration_limit = RST_ITER_LIMIT;
			expected_verdicts.delete();
			errors        = 0;
			outstanding   = 0;
			inside_count  = 0;
			outside_count = 0;
		end else begin
			// A new point: work out its verdict with the settings in force now.
			if (point.valid && point.ready) begin
				v.x          = point.point_x;
				v.y          = point.point_y;
				v.inside_res = julia_point_inside(point.point_x, point.point_y, shadow_cfg);
				expected_verdicts.push_back(v);
			end

			// A result: compare it with the oldest verdict still waiting.
			if (result.valid && result.ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("result inside_res=%b with no point waiting",
						result.inside_res));
				end else begin
					v = expected_verdicts.pop_front();
					if (result.inside_res !== v.inside_res)
						report_mismatch($sformatf("point (%h, %h): inside_res %b, expected %b",
							v.x, v.y, result.inside_res, v.inside_res));
					if (v.inside_res)
						inside_count++;
					else
						outside_count++;
				end
			end

			// Register writes; unmapped indexes leave the settings alone.
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_CENTER_REAL: shadow_cfg.center_real     = pwdata[DATA_W-1:0];
					REG_CENTER_IMAG: shadow_cfg.center_imag     = pwdata[DATA_W-1:0];
					REG_COORD_SCALE: shadow_cfg.coord_scale     = pwdata[SCALE_W-1:0];
					REG_CONST_REAL:  shadow_cfg.const_real      = pwdata[DATA_W-1:0];
					REG_CONST_IMAG:  shadow_cfg.const_imag      = pwdata[DATA_W-1:0];
					REG_ITER_LIMIT:  shadow_cfg.iteration_limit = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end

			outstanding = expected_verdicts.size();
		end
	end

endmodule

### sim/julia_set_membership_test_tb.sv
// ----------------------------------------------------------------------------
// julia_set_membership_test_tb
// Stimulus and verdict for the Julia set membership test. A directed part hits
// the boundary of the escape test, start and iterate overflow, a zero limit
// and the largest limit; random phases then sweep register settings and points.
// ----------------------------------------------------------------------------
module julia_set_membership_test_tb;
	import jsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 600;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_POINTS   = 150;

	localparam logic [REG_IDX_W-1:0]     REG_UNMAPPED = 3'd7;
	localparam logic signed [DATA_W-1:0] Q_MAX        = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN        = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_ONE        = 32'sh1000_0000;
	localparam logic signed [DATA_W-1:0] Q_NEAR_8     = 32'sh7F00_0000;
	localparam logic [SCALE_W-1:0]       SCALE_MAX    = 31'h7FFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatch_count;
	int points_in_flight;
	int inside_total;
	int outside_total;
	int settings_used;
	int quiet_cycles;
	int hold_left;
	bit calm;

	jsm_point_if  point_ch();
	jsm_result_if result_ch();

	julia_set_membership_test uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (point_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	julia_set_membership_test_checker verdict_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.point         (point_ch),
		.result        (result_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.errors        (mismatch_count),
		.outstanding   (points_in_flight),
		.inside_count  (inside_total),
		.outside_count (outside_total)
	);

	// Clock with a period of 4.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: ready drops in random bursts, except in the calm last phase.
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				hold_left = $urandom_range(1, 16) - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no request moves for too long.
	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(psel && penable) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: nothing accepted for %0d cycles, %0d points still open",
				quiet_cycles, points_in_flight);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stop offering points and wait until every verdict has been checked.
	task automatic wait_drained();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (points_in_flight != 0)
			@(negedge clk);
	endtask

	// Write the whole register set once the block is idle.
	task automatic load_settings(input cfg_t s);
		wait_drained();
		write_reg(REG_CENTER_REAL, s.center_real);
		write_reg(REG_CENTER_IMAG, s.center_imag);
		write_reg(REG_COORD_SCALE, {1'($urandom_range(0, 1)), s.coord_scale});
		write_reg(REG_CONST_REAL, s.const_real);
		write_reg(REG_CONST_IMAG, s.const_imag);
		write_reg(REG_ITER_LIMIT, {24'($urandom()), s.iteration_limit});
		settings_used++;
	endtask

	// Offer one point, after a random gap unless the run is in its calm part.
	task automatic send_point(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] y);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			point_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		point_ch.valid   <= 1'b1;
		point_ch.point_x <= x;
		point_ch.point_y <= y;
		do @(posedge clk); while (!point_ch.ready);
	endtask

	initial begin
		cfg_t                     s;
		logic signed [DATA_W-1:0] px;
		logic signed [DATA_W-1:0] py;
		longint                   sc;
		longint                   tr;
		longint                   ti;
		int                       k;
		int                       n;

		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		point_ch.valid   = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		arst_n           = 1'b0;
		calm             = 1'b0;
		settings_used    = 1;
		quiet_cycles     = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes and a few points near the origin.
		send_point('0, '0);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MAX);
		send_point(Q_ONE >>> 2, -(Q_ONE >>> 2));

		// Unit scale, c = -2: the origin rides the escape bound exactly,
		// large starts overflow on the first step.
		s.center_real     = '0;
		s.center_imag     = '0;
		s.coord_scale     = Q_ONE[SCALE_W-1:0];
		s.const_real      = -(Q_ONE <<< 1);
		s.const_imag      = '0;
		s.iteration_limit = 8'd10;
		load_settings(s);
		send_point('0, '0);
		send_point(Q_NEAR_8, '0);
		send_point('0, Q_NEAR_8);
		send_point(Q_ONE, Q_ONE);
		send_point(Q_MIN, Q_MIN);

		// Extreme center and scale with a zero limit: the start value decides.
		s.center_real     = Q_MAX;
		s.center_imag     = Q_MIN;
		s.coord_scale     = SCALE_MAX;
		s.const_real      = Q_MIN;
		s.const_imag      = Q_MAX;
		s.iteration_limit = 8'd0;
		load_settings(s);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MAX - 1, Q_MIN + 1);
		// A write past the register list must change nothing.
		wait_drained();
		write_reg(REG_UNMAPPED, '1);
		send_point(Q_MAX - 1, Q_MIN + 1);

		// Zero scale and the largest limit: every point starts at the origin.
		s.center_real     = '0;
		s.center_imag     = '0;
		s.coord_scale     = '0;
		s.const_real      = RST_CONST_REAL;
		s.const_imag      = RST_CONST_IMAG;
		s.iteration_limit = 8'd255;
		load_settings(s);
		send_point('0, '0);
		send_point(Q_MAX, Q_MIN);
		send_point(32'sd12345, -32'sd999);

		// Random phases; the last one runs without idling on either side.
		for (k = 0; k <= RANDOM_PHASES; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				s.center_real = $urandom();
				s.center_imag = $urandom();
			end else begin
				s.center_real = $signed($urandom()) >>> 3;
				s.center_imag = $signed($urandom()) >>> 3;
			end
			if ($urandom_range(0, 3) == 0)
				s.coord_scale = SCALE_W'($urandom());
			else
				s.coord_scale = SCALE_W'($urandom_range(32'h0400_0000, 32'h1800_0000));
			if ($urandom_range(0, 4) == 0) begin
				s.const_real = $urandom();
				s.const_imag = $urandom();
			end else begin
				s.const_real = $signed($urandom()) >>> 3;
				s.const_imag = $signed($urandom()) >>> 3;
			end
			if ($urandom_range(0, 5) == 0)
				s.iteration_limit = CNT_W'($urandom_range(1, 255));
			else
				s.iteration_limit = CNT_W'($urandom_range(2, 40));
			// Push some phases to the ends of the register ranges.
			case (k)
				0: s.iteration_limit = 8'd255;
				1: s.iteration_limit = 8'd1;
				2: s.iteration_limit = 8'd0;
				3: s.coord_scale = SCALE_MAX;
				4: s.coord_scale = '0;
				5: begin
					s.center_real = Q_MIN;
					s.center_imag = Q_MAX;
					s.const_real  = Q_MAX;
					s.const_imag  = Q_MIN;
				end
				default: ;
			endcase
			load_settings(s);
			calm = (k == RANDOM_PHASES);

			sc = longint'({33'd0, s.coord_scale});
			for (n = 0; n < PHASE_POINTS; n++) begin
				// Most points aim at a start value with both parts within 2 of the origin.
				if ($urandom_range(0, 9) < 4 || sc == 0) begin
					px = $urandom();
					py = $urandom();
				end else begin
					tr = longint'($signed($urandom())) >>> 2;
					ti = longint'($signed($urandom())) >>> 2;
					px = DATA_W'(longint'($signed(s.center_real)) + (tr <<< FRACTION_BITS) / sc);
					py = DATA_W'(longint'($signed(s.center_imag)) + (ti <<< FRACTION_BITS) / sc);
				end
				if (!calm && $urandom_range(0, 63) == 0)
					wait_drained();
				send_point(px, py);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d points over %0d register settings: %0d inside, %0d outside.",
			inside_total + outside_total, settings_used, inside_total, outside_total);
		if (mismatch_count == 0 && points_in_flight == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### julia_set_membership_test.f
rtl/jsm_pkg.sv
rtl/jsm_ifs.sv
rtl/jsm_cfg.sv
rtl/jsm_dp.sv
rtl/jsm_ctrl.sv
rtl/julia_set_membership_test.sv
sim/julia_set_membership_test_checker.sv
sim/julia_set_membership_test_tb.sv
